[hw/rtl/dlp_pkg.sv]
// ----------------------------------------------------------------------------
// Difference low-pass package
// Shared constants and types for the separable 1-5-1 difference filter.
// ----------------------------------------------------------------------------
package dlp_pkg;

   // Configuration register indexes.
   localparam logic [7:0] CSR_BLOCK_WIDTH  = 8'd0;
   localparam logic [7:0] CSR_BLOCK_HEIGHT = 8'd1;

   // Field widths fixed by the stream format.
   localparam int PIX_W  = 12;
   localparam int DIFF_W = 13;
   localparam int HF_W   = 16;
   localparam int VAL_W  = 19;
   localparam int ROW_W  = 12;
   localparam int COL_W  = 8;
   localparam int BW_W   = 9;

   // Number of result slots one request can fill.
   localparam int MAX_RESULTS = 4;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [VAL_W-1:0] value;
      logic             last;
      logic             done;
   } rsp_entry_type;

endpackage

[hw/rtl/difference_lowpass_151_2d.sv]
// ----------------------------------------------------------------------------
// Difference low-pass filter, separable 1-5-1, two dimensional
//
// Takes source and reference pixels in raster order on the req_ channel and
// returns the row- and column-filtered difference on the rsp_ channel, each
// result tagged with its row and column. Pixel 0 of a row and all of row 0
// give no result; other pixels give one (two in the last row), and the last
// pixel of a row gives twice that. rsp_tlast marks the last result of a
// request and rsp_tuser marks the final result of the block.
// An accepted request is registered in the request stage; its results then
// load into the output queue. Throughput: one request per cycle while each
// gives at most one result and rsp_tready is high; one giving more holds the
// next back until its last result leaves, as results go out one a cycle.
// The line buffers are two RAM banks split by column parity, so a request
// reads and writes each bank at most once.
// Reset, or any csr_ write, restarts the block at row 0, column 0; the size
// registers reset to 8 x 8. The line buffers need no clearing.
// When the receiver stalls, results wait in a four-entry output queue and
// the request stage holds, dropping req_tready.
// ----------------------------------------------------------------------------
module difference_lowpass_151_2d #(
   parameter int MAX_WIDTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   // tdata: pixel_src [11:0], pixel_ref [23:12]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // tdata: out_row [11:0], out_col [19:12], filtered [38:20], zero [39]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   // tuser: block_done [0]
   output logic [0:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [11:0] csr_data
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int AW    = CW - 1;
   localparam int DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int LW    = 2 * dlp_pkg::HF_W;

   // Configuration and position state.
   logic [dlp_pkg::BW_W-1:0]          block_width_ff;
   logic [dlp_pkg::ROW_W-1:0]         block_height_ff;
   logic [CW-1:0]                     col_ff, col_in;
   logic [dlp_pkg::ROW_W-1:0]         row_ff, row_in;
   logic signed [dlp_pkg::DIFF_W-1:0] diff_prev_ff, diff_prev_in;
   logic signed [dlp_pkg::DIFF_W-1:0] diff_prev2_ff, diff_prev2_in;

   // Request stage.
   logic                            p_valid_ff, p_valid_in;
   logic [CW-1:0]                   p_col_ff;
   logic [dlp_pkg::ROW_W-1:0]       p_row_ff;
   logic signed [dlp_pkg::HF_W-1:0] p_ha_ff, p_hb_ff;
   logic                            p_has_a_ff, p_has_b_ff, p_last_row_ff, p_last_pix_ff;

   // Output queue.
   dlp_pkg::rsp_entry_type q_ff [dlp_pkg::MAX_RESULTS];
   dlp_pkg::rsp_entry_type q_in [dlp_pkg::MAX_RESULTS];
   logic [2:0]             q_cnt_ff, q_cnt_in;

   logic                              csr_go, req_go, rsp_take, p_go;
   logic [dlp_pkg::PIX_W-1:0]         pix_src, pix_ref;
   logic signed [dlp_pkg::DIFF_W-1:0] diff;
   logic [WW-1:0]                     w_eff;
   logic [dlp_pkg::ROW_W-1:0]         rows_eff;
   logic                              col_last, bottom_row;
   logic signed [dlp_pkg::HF_W-1:0]   d16, dp16, dp2_16, ha, hb;
   logic [CW-1:0]                     col_m1;

   assign csr_ready = 1'b1;
   assign csr_go    = csr_valid && csr_ready;
   assign rsp_take  = rsp_tvalid && rsp_tready;
   assign p_go      = p_valid_ff && ((q_cnt_ff == 3'd0) || ((q_cnt_ff == 3'd1) && rsp_tready));
   assign req_tready = !p_valid_ff || p_go;
   assign req_go    = req_tvalid && req_tready;

   assign pix_src = req_tdata[11:0];
   assign pix_ref = req_tdata[23:12];
   assign diff    = $signed({1'b0, pix_src}) - $signed({1'b0, pix_ref});

   // Effective block size: width clamped to 2..MAX_WIDTH, height to at least 2.
   always_comb begin
      if (block_width_ff < dlp_pkg::BW_W'(2)) begin
         w_eff = WW'(2);
      end else if (32'(block_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(block_width_ff);
      end
      if (block_height_ff < dlp_pkg::ROW_W'(2)) begin
         rows_eff = dlp_pkg::ROW_W'(2);
      end else begin
         rows_eff = block_height_ff;
      end
   end

   assign col_last   = (WW'(col_ff) + WW'(1)) == w_eff;
   assign bottom_row = (13'(row_ff) + 13'd1) == 13'(rows_eff);
   assign col_m1     = col_ff - CW'(1);

   // Horizontal filter: column c-1 from three taps (two for column 0), the last column from two.
   assign d16    = 16'(diff);
   assign dp16   = 16'(diff_prev_ff);
   assign dp2_16 = 16'(diff_prev2_ff);
   assign ha = (col_ff == CW'(1)) ? (dp16 <<< 2) + dp16 + (d16 <<< 1)
                                  : dp2_16 + (dp16 <<< 2) + dp16 + d16;
   assign hb = (d16 <<< 2) + d16 + (dp16 <<< 1);

   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      diff_prev_in  = diff_prev_ff;
      diff_prev2_in = diff_prev2_ff;
      if (csr_go) begin
         col_in        = '0;
         row_in        = '0;
         diff_prev_in  = '0;
         diff_prev2_in = '0;
      end else if (req_go) begin
         if (col_last) begin
            col_in        = '0;
            diff_prev_in  = '0;
            diff_prev2_in = '0;
            row_in        = bottom_row ? '0 : row_ff + dlp_pkg::ROW_W'(1);
         end else begin
            col_in        = col_ff + CW'(1);
            diff_prev_in  = diff;
            diff_prev2_in = diff_prev_ff;
         end
      end
   end

   always_comb begin
      p_valid_in = p_valid_ff;
      if (req_go) begin
         p_valid_in = 1'b1;
      end else if (p_go) begin
         p_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_width_ff  <= dlp_pkg::BW_W'(8);
         block_height_ff <= dlp_pkg::ROW_W'(8);
         col_ff          <= '0;
         row_ff          <= '0;
         diff_prev_ff    <= '0;
         diff_prev2_ff   <= '0;
         p_valid_ff      <= 1'b0;
         q_cnt_ff        <= '0;
      end else begin
         if (csr_go && (csr_index == dlp_pkg::CSR_BLOCK_WIDTH)) begin
            block_width_ff <= csr_data[dlp_pkg::BW_W-1:0];
         end
         if (csr_go && (csr_index == dlp_pkg::CSR_BLOCK_HEIGHT)) begin
            block_height_ff <= csr_data;
         end
         col_ff        <= col_in;
         row_ff        <= row_in;
         diff_prev_ff  <= diff_prev_in;
         diff_prev2_ff <= diff_prev2_in;
         p_valid_ff    <= p_valid_in;
         q_cnt_ff      <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         p_col_ff      <= col_ff;
         p_row_ff      <= row_ff;
         p_ha_ff       <= ha;
         p_hb_ff       <= hb;
         p_has_a_ff    <= col_ff != '0;
         p_has_b_ff    <= col_last;
         p_last_row_ff <= bottom_row;
         p_last_pix_ff <= col_last && bottom_row;
      end
      q_ff <= q_in;
   end

   // Line buffers, one bank per column parity. Each word holds the
   // row-filtered values of the newer row [31:16] and the older row [15:0].
   logic          rd_en;
   logic [AW-1:0] rd_addr [2];
   logic [LW-1:0] rd_data [2];
   logic          wr_en   [2];
   logic [AW-1:0] wr_addr [2];
   logic [LW-1:0] wr_data [2];

   assign rd_en = req_go;

   logic                            a_bank;
   logic [LW-1:0]                   line_a, line_b;
   logic signed [dlp_pkg::HF_W-1:0] older_a, newer_a, older_b, newer_b;
   logic [CW-1:0]                   p_col_m1;

   assign p_col_m1 = p_col_ff - CW'(1);
   assign a_bank   = p_col_m1[0];
   assign line_a   = a_bank ? rd_data[1] : rd_data[0];
   assign line_b   = p_col_ff[0] ? rd_data[1] : rd_data[0];
   assign older_a  = line_a[dlp_pkg::HF_W-1:0];
   assign newer_a  = line_a[LW-1:dlp_pkg::HF_W];
   assign older_b  = line_b[dlp_pkg::HF_W-1:0];
   assign newer_b  = line_b[LW-1:dlp_pkg::HF_W];

   for (genvar k = 0; k < 2; k++) begin : g_bank
      assign rd_addr[k] = (col_ff[0] == 1'(k)) ? col_ff[CW-1:1] : col_m1[CW-1:1];

      always_comb begin
         if (p_has_b_ff && (p_col_ff[0] == 1'(k))) begin
            wr_en[k]   = p_go;
            wr_addr[k] = p_col_ff[CW-1:1];
            wr_data[k] = {p_hb_ff, newer_b};
         end else begin
            wr_en[k]   = p_go && p_has_a_ff && (a_bank == 1'(k));
            wr_addr[k] = p_col_m1[CW-1:1];
            wr_data[k] = {p_ha_ff, newer_a};
         end
      end

      dlp_ram #(
         .DATA_WIDTH (LW),
         .DEPTH      (DEPTH)
      ) u_line (
         .clock   (clock),
         .wr_en   (wr_en[k]),
         .wr_addr (wr_addr[k]),
         .wr_data (wr_data[k]),
         .rd_en   (rd_en),
         .rd_addr (rd_addr[k]),
         .rd_data (rd_data[k])
      );
   end

   // Vertical filter for the completed columns.
   logic signed [dlp_pkg::VAL_W-1:0] ha19, hb19, na19, oa19, nb19, ob19;
   logic signed [dlp_pkg::VAL_W-1:0] va1, va2, vb1, vb2;
   logic                             r_ge1, r_eq1;

   assign ha19  = 19'(p_ha_ff);
   assign hb19  = 19'(p_hb_ff);
   assign na19  = 19'(newer_a);
   assign oa19  = 19'(older_a);
   assign nb19  = 19'(newer_b);
   assign ob19  = 19'(older_b);
   assign r_ge1 = p_row_ff != '0;
   assign r_eq1 = p_row_ff == dlp_pkg::ROW_W'(1);

   assign va1 = r_eq1 ? (na19 <<< 2) + na19 + (ha19 <<< 1)
                      : oa19 + (na19 <<< 2) + na19 + ha19;
   assign va2 = (ha19 <<< 2) + ha19 + (na19 <<< 1);
   assign vb1 = r_eq1 ? (nb19 <<< 2) + nb19 + (hb19 <<< 1)
                      : ob19 + (nb19 <<< 2) + nb19 + hb19;
   assign vb2 = (hb19 <<< 2) + hb19 + (nb19 <<< 1);

   // Gather the results of this request in output order.
   dlp_pkg::rsp_entry_type cand [dlp_pkg::MAX_RESULTS];
   dlp_pkg::rsp_entry_type list [dlp_pkg::MAX_RESULTS];
   logic [dlp_pkg::MAX_RESULTS-1:0] cand_valid;
   logic [2:0]                      n_res;
   logic [dlp_pkg::ROW_W-1:0]       row_m1;

   assign row_m1 = p_row_ff - dlp_pkg::ROW_W'(1);

   always_comb begin
      cand[0] = '{row: row_m1,   col: 8'(p_col_m1), value: va1, last: 1'b0, done: 1'b0};
      cand[1] = '{row: p_row_ff, col: 8'(p_col_m1), value: va2, last: 1'b0, done: 1'b0};
      cand[2] = '{row: row_m1,   col: 8'(p_col_ff), value: vb1, last: 1'b0, done: 1'b0};
      cand[3] = '{row: p_row_ff, col: 8'(p_col_ff), value: vb2, last: 1'b0, done: 1'b0};
      cand_valid[0] = r_ge1 && p_has_a_ff;
      cand_valid[1] = r_ge1 && p_has_a_ff && p_last_row_ff;
      cand_valid[2] = r_ge1 && p_has_b_ff;
      cand_valid[3] = r_ge1 && p_has_b_ff && p_last_row_ff;
   end

   always_comb begin
      n_res = '0;
      for (int j = 0; j < dlp_pkg::MAX_RESULTS; j++) begin
         list[j] = '0;
      end
      for (int i = 0; i < dlp_pkg::MAX_RESULTS; i++) begin
         if (cand_valid[i]) begin
            list[n_res[1:0]] = cand[i];
            n_res = n_res + 3'd1;
         end
      end
      for (int j = 0; j < dlp_pkg::MAX_RESULTS; j++) begin
         list[j].last = (3'(j) + 3'd1) == n_res;
         list[j].done = list[j].last && p_last_pix_ff;
      end
   end

   // The queue loads when it is empty or its last entry leaves this cycle.
   always_comb begin
      q_in     = q_ff;
      q_cnt_in = q_cnt_ff;
      if (p_go) begin
         q_in     = list;
         q_cnt_in = n_res;
      end else if (rsp_take) begin
         for (int j = 0; j < dlp_pkg::MAX_RESULTS - 1; j++) begin
            q_in[j] = q_ff[j+1];
         end
         q_cnt_in = q_cnt_ff - 3'd1;
      end
   end

   assign rsp_tvalid   = q_cnt_ff != '0;
   assign rsp_tdata    = {1'b0, q_ff[0].value, q_ff[0].col, q_ff[0].row};
   assign rsp_tlast    = q_ff[0].last;
   assign rsp_tuser[0] = q_ff[0].done;

   // The queue never holds more results than one request can give.
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= 3'(dlp_pkg::MAX_RESULTS))
      else $error("output queue count out of range");

   // The request stage only holds while results are still waiting.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (p_valid_ff && !p_go) |-> (q_cnt_ff != '0))
      else $error("request stage stalled with an empty queue");

   // The end of the block is always the last result of its request.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tlast)
      else $error("block end flagged on a result that is not last");

   // Reset leaves the pipeline empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!p_valid_ff && (q_cnt_ff == '0)))
      else $error("pipeline not empty after reset");

endmodule

[hw/rtl/dlp_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module dlp_ram #(
   parameter int DATA_WIDTH = 32,
   parameter int DEPTH      = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[tb/sv/dlp_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Difference low-pass result checker
// Watches the request, result and register channels of the 1-5-1 filter,
// keeps its own copy of the filter state, predicts the results of every
// accepted request and compares each accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module dlp_result_checker #(
   parameter int MAX_WIDTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic [0:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [11:0] csr_data,
   output int          mismatch_count,
   output int          results_due
);

   logic [dlp_pkg::BW_W-1:0]  width_reg;
   logic [dlp_pkg::ROW_W-1:0] height_reg;
   int diff_last;
   int diff_before;
   int hrow_older [MAX_WIDTH];
   int hrow_newer [MAX_WIDTH];
   int col_pos;
   int row_pos;
   int fail_total;
   int step_n;
   dlp_pkg::rsp_entry_type step_out [dlp_pkg::MAX_RESULTS];
   dlp_pkg::rsp_entry_type due_results [$];

   task automatic restart_block();
      diff_last   = 0;
      diff_before = 0;
      col_pos     = 0;
      row_pos     = 0;
   endtask

   task automatic emit(input int row, input int col, input int v);
      step_out[step_n].row   = row[dlp_pkg::ROW_W-1:0];
      step_out[step_n].col   = col[dlp_pkg::COL_W-1:0];
      step_out[step_n].value = v[dlp_pkg::VAL_W-1:0];
      step_out[step_n].last  = 1'b0;
      step_out[step_n].done  = 1'b0;
      step_n++;
   endtask

   // Column filter for one column whose row-filtered value has just become known.
   task automatic vertical_pass(input int col, input int h, input int rows);
      int older;
      int newer;
      older = hrow_older[col];
      newer = hrow_newer[col];
      if (row_pos >= 1) begin
         emit(row_pos - 1, col, (row_pos == 1) ? 5 * newer + 2 * h : older + 5 * newer + h);
         // In the last row the bottom output row is finished in the same step.
         if (row_pos + 1 >= rows)
            emit(row_pos, col, 5 * h + 2 * newer);
      end
      hrow_older[col] = newer;
      hrow_newer[col] = h;
   endtask

   task automatic filter_pixel(input logic [11:0] src, input logic [11:0] pref);
      int w;
      int rows;
      int d;
      int c;
      int i;
      bit last_pix;
      w = (width_reg < 2) ? 2 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
      rows = (height_reg < 2) ? 2 : int'(height_reg);
      d = int'(src) - int'(pref);
      c = col_pos;
      if (c >= w) c = w - 1;
      if (row_pos >= rows) row_pos = rows - 1;
      step_n = 0;
      if (c >= 1)
         vertical_pass(c - 1, (c == 1) ? 5 * diff_last + 2 * d
                                       : diff_before + 5 * diff_last + d, rows);
      if (c + 1 == w)
         vertical_pass(c, 5 * d + 2 * diff_last, rows);
      diff_before = diff_last;
      diff_last   = d;
      last_pix = (c + 1 == w) && (row_pos + 1 == rows);
      if (c + 1 == w) begin
         col_pos     = 0;
         diff_last   = 0;
         diff_before = 0;
         row_pos     = last_pix ? 0 : row_pos + 1;
      end else begin
         col_pos = c + 1;
      end
      if (step_n > 0) begin
         step_out[step_n-1].last = 1'b1;
         step_out[step_n-1].done = last_pix;
      end
      for (i = 0; i < step_n; i++)
         due_results.push_back(step_out[i]);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_total++;
      end
   endtask

   initial begin
      width_reg  = 9'd8;
      height_reg = 12'd8;
      fail_total = 0;
      restart_block();
   end

   always @(posedge clock) begin : watch
      dlp_pkg::rsp_entry_type want;
      if (reset) begin
         width_reg  = 9'd8;
         height_reg = 12'd8;
         restart_block();
         due_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dlp_pkg::CSR_BLOCK_WIDTH: begin
                  width_reg = csr_data[dlp_pkg::BW_W-1:0];
                  restart_block();
               end
               dlp_pkg::CSR_BLOCK_HEIGHT: begin
                  height_reg = csr_data;
                  restart_block();
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            filter_pixel(req_tdata[11:0], req_tdata[23:12]);
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               $error("result with nothing due: row %0d, col %0d",
                      rsp_tdata[11:0], rsp_tdata[19:12]);
               fail_total++;
            end else begin
               want = due_results.pop_front();
               check_field("out_row", int'(want.row), int'(rsp_tdata[11:0]));
               check_field("out_col", int'(want.col), int'(rsp_tdata[19:12]));
               check_field("filtered", int'($signed(want.value)),
                           int'($signed(rsp_tdata[38:20])));
               check_field("pad", 0, int'(rsp_tdata[39]));
               check_field("run_last", int'(want.last), int'(rsp_tlast));
               check_field("block_done", int'(want.done), int'(rsp_tuser[0]));
            end
         end
      end
      mismatch_count <= fail_total;
      results_due    <= due_results.size();
   end

endmodule

[tb/sv/difference_lowpass_151_2d_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Difference low-pass filter testbench
// Drives pixel pairs and block size writes into the 1-5-1 filter, with random
// gaps and stalls on both streams, and leaves prediction and comparison to
// the result checker beside the block.
// ----------------------------------------------------------------------------
module difference_lowpass_151_2d_tb;

   localparam int MAX_WIDTH    = 256;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_HOLD    = 80;
   localparam int HOLD_ITEMS   = 32;
   localparam int RANDOM_ITEMS = 80;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index  = '0;
   logic [11:0] csr_data   = '0;
   int          mismatch_count;
   int          results_due;

   logic quiet        = 1'b0;
   logic hold_request = 1'b0;
   int   cur_w        = 8;
   int   cur_h        = 8;

   difference_lowpass_151_2d #(.MAX_WIDTH(MAX_WIDTH)) dut (.*);

   dlp_result_checker #(.MAX_WIDTH(MAX_WIDTH)) result_checker (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [11:0] any_sample();
      case ($urandom_range(0, 7))
         0:       any_sample = 12'h000;
         1:       any_sample = 12'hFFF;
         default: any_sample = 12'($urandom_range(0, 4095));
      endcase
   endfunction

   task automatic send_pixel(input logic [11:0] src, input logic [11:0] pref);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pref, src};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering requests and waits until every predicted result is back.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
   endtask

   task automatic set_size(input bit wr_w, input int w, input bit wr_h, input int h);
      drain();
      // A request that gives no result may still be in flight.
      repeat (4) @(posedge clock);
      if (wr_w) begin
         csr_valid <= 1'b1;
         csr_index <= dlp_pkg::CSR_BLOCK_WIDTH;
         csr_data  <= 12'(w);
         do @(posedge clock); while (!csr_ready);
         cur_w = w;
      end
      if (wr_h) begin
         csr_valid <= 1'b1;
         csr_index <= dlp_pkg::CSR_BLOCK_HEIGHT;
         csr_data  <= 12'(h);
         do @(posedge clock); while (!csr_ready);
         cur_h = h;
      end
      csr_valid <= 1'b0;
   endtask

   initial begin : result_sink
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!quiet && !reset && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      int i;
      int sel;
      int wf;
      int hf;
      int n_items;
      int pause_at;
      int random_done;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset size of 8 x 8, alternating extreme differences, left mid-block.
      for (i = 0; i < 10; i++)
         send_pixel((i % 2) ? 12'h000 : 12'hFFF, (i % 2) ? 12'hFFF : 12'h000);
      // Sizes below the minimum act as 2 x 2; the whole block is the most negative.
      set_size(1'b1, 1, 1'b1, 0);
      for (i = 0; i < 4; i++)
         send_pixel(12'h000, 12'hFFF);
      set_size(1'b1, 3, 1'b1, 3);
      for (i = 0; i < 9; i++)
         send_pixel(12'hFFF, 12'h000);

      // The receiver holds off for a long stretch while requests keep coming.
      set_size(1'b1, 8, 1'b1, 8);
      for (i = 0; i < HOLD_ITEMS; i++) begin
         if (i == 10)
            hold_request <= 1'b1;
         send_pixel(any_sample(), any_sample());
      end
      random_done = HOLD_ITEMS;

      while (random_done < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 3);
         case ($urandom_range(0, 9))
            0:       wf = $urandom_range(0, 1);
            1:       wf = $urandom_range(11, 40);
            default: wf = $urandom_range(2, 10);
         endcase
         case ($urandom_range(0, 9))
            0:       hf = $urandom_range(0, 1);
            1:       hf = $urandom_range(7, 12);
            default: hf = $urandom_range(2, 6);
         endcase
         set_size(sel != 1, wf, sel != 0, hf);
         wf = (cur_w < 2) ? 2 : ((cur_w > MAX_WIDTH) ? MAX_WIDTH : cur_w);
         hf = (cur_h < 2) ? 2 : cur_h;
         case ($urandom_range(0, 9))
            0, 1, 2: n_items = $urandom_range(1, wf * hf - 1);
            3:       n_items = 2 * wf * hf;
            default: n_items = wf * hf;
         endcase
         if (n_items > RANDOM_ITEMS - random_done)
            n_items = RANDOM_ITEMS - random_done;
         pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n_items) : -1;
         for (i = 0; i < n_items; i++) begin
            if (i == pause_at)
               drain();
            send_pixel(any_sample(), any_sample());
         end
         random_done += n_items;
      end

      // Tallest block, abandoned after some rows by the next write.
      set_size(1'b1, 2, 1'b1, 4095);
      for (i = 0; i < 16; i++)
         send_pixel(any_sample(), any_sample());

      // Widest block, width above the limit and height below it, at full rate:
      // the first row and the start of the last one.
      quiet <= 1'b1;
      set_size(1'b1, 511, 1'b1, 1);
      for (i = 0; i < MAX_WIDTH + 4; i++)
         send_pixel(any_sample(), any_sample());

      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && results_due == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
